// ----- src/rau_pkg.sv -----
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps
package rau_pkg;
    localparam int DEF_WIDTH = 32;
    localparam int MW = 2 * DEF_WIDTH + 1;

    typedef enum logic [2:0] {
        FN_NORM = 3'd0,
        FN_ADD  = 3'd1,
        FN_SUB  = 3'd2,
        FN_MUL  = 3'd3,
        FN_DIV  = 3'd4
    } func_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL1,
        CMD_MUL2,
        CMD_SUM,
        CMD_GCD_INIT,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_GCD_NEXT,
        CMD_QN_INIT,
        CMD_QD_INIT,
        CMD_FINISH
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic gcd_done;
        logic zden;
    } stat_t;
endpackage

// ----- src/rational_arithmetic_unit.sv -----
// Top level of the rational arithmetic unit.
// Depends on rau_pkg, rau_ctrl, rau_datapath.
//
//  channel  | dir | tdata fields (low bit up)
//  s_axis   | in  | func[2:0] a_num[34:3] a_den[66:35] b_num[98:67] b_den[130:99]
//  m_axis   | out | res_num[31:0] res_den[62:32] status[64:63]
//
// One request at a time. A zero denominator skips the GCD and the reduction.
// Otherwise each Euclid remainder step is one divide, one bit a cycle in a
// (2*WIDTH+1)-step divider, and two divides by the GCD follow. Reset clears
// the sequencer; no clearing pass. A stalled result holds in its register
// and blocks the next request until it is accepted.
`timescale 1ns / 1ps
module rational_arithmetic_unit #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // func, a_num, a_den, b_num, b_den
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata   // res_num, res_den, status
);
    import rau_pkg::*;
    cmd_t cmd;
    stat_t stat;
    logic [31:0] rn;
    logic [30:0] rd;
    logic [1:0] st;

    rau_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .stat(stat), .cmd(cmd)
    );

    rau_datapath #(.WIDTH(WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .func_in(s_axis_tdata[2:0]), .opnd(s_axis_tdata[130:3]),
        .stat(stat), .res_num(rn), .res_den(rd), .status(st)
    );

    assign m_axis_tdata = {7'd0, st, rd, rn};
endmodule

// ----- src/rau_datapath.sv -----
// Datapath of the rational arithmetic unit: operand registers, one shared
// multiplier, a restoring divider used for the Euclidean GCD and the reduction.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_datapath #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rau_pkg::cmd_t       cmd,
    input  logic [2:0]          func_in,
    input  logic [4*32-1:0]     opnd,
    output rau_pkg::stat_t      stat,
    output logic [31:0]         res_num,
    output logic [30:0]         res_den,
    output logic [1:0]          status
);
    import rau_pkg::*;
    localparam int W2 = 2 * WIDTH + 1;
    localparam int CW = $clog2(W2 + 1);

    logic [WIDTH:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic [2:0] fn_reg;
    logic [W2-1:0] p1_reg, p2_reg, num_reg, den_reg;
    logic num_s_reg, p1_s_reg, p2_s_reg;
    logic [W2-1:0] x_reg, y_reg, g_reg;
    logic [W2-1:0] rem_reg, quo_reg, dvd_reg, dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic [W2-1:0] qn_reg;
    logic [1:0] qsel_reg;
    logic [31:0] rn_reg;
    logic [30:0] rd_reg;
    logic [1:0] st_reg;

    function automatic logic [WIDTH:0] mag_of(input logic [31:0] raw);
        logic [WIDTH-1:0] v;
        v = raw[WIDTH-1:0];
        return v[WIDTH-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
    endfunction

    logic [WIDTH:0] ma, mb;
    logic ma_s, mb_s;
    logic [2*WIDTH+1:0] prod_full;
    logic [W2-1:0] prod;
    logic [W2:0] trial;
    logic [W2-1:0] lim;
    logic fbin;

    assign fbin = (fn_reg >= FN_ADD) && (fn_reg <= FN_DIV);
    assign lim = {{(W2-WIDTH){1'b0}}, 1'b1, {(WIDTH-1){1'b0}}};

    always_comb
    begin
        ma = an_reg; ma_s = an_s_reg; mb = bd_reg; mb_s = bd_s_reg;
        if (cmd == CMD_MUL2)
        begin
            unique case (fn_reg)
                FN_ADD, FN_SUB:
                begin
                    ma = bn_reg; ma_s = bn_s_reg ^ (fn_reg == FN_SUB); mb = ad_reg;
                    mb_s = ad_s_reg;
                end
                FN_MUL:
                begin
                    ma = an_reg; ma_s = an_s_reg; mb = bn_reg; mb_s = bn_s_reg;
                end
                default:
                begin
                    ma = an_reg; ma_s = an_s_reg; mb = bd_reg; mb_s = bd_s_reg;
                end
            endcase
        end
        else if (cmd == CMD_SUM)
        begin
            ma = ad_reg; ma_s = ad_s_reg;
            mb = (fn_reg == FN_DIV) ? bn_reg : bd_reg;
            mb_s = (fn_reg == FN_DIV) ? bn_s_reg : bd_s_reg;
        end
        // products are at most 2^(2*WIDTH-2), so the top bit is always clear
        prod_full = ma * mb;
        prod = prod_full[W2-1:0];
    end

    assign trial = {rem_reg, dvd_reg[W2-1]} - {1'b0, dvs_reg};

    assign stat.zden = (ad_reg == '0) || (fbin && bd_reg == '0)
                     || (fn_reg == FN_DIV && bn_reg == '0);
    assign stat.div_done = (cnt_reg == '0);
    assign stat.gcd_done = (y_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            st_reg <= ST_OK;
        end
        else
        begin
            unique case (cmd)
                CMD_LOAD:
                begin
                    fn_reg <= func_in;
                    an_reg <= mag_of(opnd[31:0]);   an_s_reg <= opnd[WIDTH-1];
                    ad_reg <= mag_of(opnd[63:32]);  ad_s_reg <= opnd[32+WIDTH-1];
                    bn_reg <= mag_of(opnd[95:64]);  bn_s_reg <= opnd[64+WIDTH-1];
                    bd_reg <= mag_of(opnd[127:96]); bd_s_reg <= opnd[96+WIDTH-1];
                end
                CMD_MUL1:
                begin
                    p1_reg <= prod; p1_s_reg <= ma_s ^ mb_s;
                end
                CMD_MUL2:
                begin
                    p2_reg <= prod; p2_s_reg <= ma_s ^ mb_s;
                end
                CMD_SUM:
                begin
                    // den magnitude from third product for two-operand kinds; numerator by kind
                    if (fbin)
                    begin
                        den_reg <= prod;
                        if (fn_reg == FN_MUL || fn_reg == FN_DIV)
                        begin
                            num_reg <= p2_reg;
                            num_s_reg <= p2_s_reg ^ ma_s ^ mb_s;
                        end
                        else if (p1_s_reg == p2_s_reg)
                        begin
                            num_reg <= p1_reg + p2_reg;
                            num_s_reg <= p1_s_reg ^ ma_s ^ mb_s;
                        end
                        else if (p1_reg >= p2_reg)
                        begin
                            num_reg <= p1_reg - p2_reg;
                            num_s_reg <= p1_s_reg ^ ma_s ^ mb_s;
                        end
                        else
                        begin
                            num_reg <= p2_reg - p1_reg;
                            num_s_reg <= p2_s_reg ^ ma_s ^ mb_s;
                        end
                    end
                    else
                    begin
                        num_reg <= {{(W2-WIDTH-1){1'b0}}, an_reg};
                        den_reg <= {{(W2-WIDTH-1){1'b0}}, ad_reg};
                        num_s_reg <= an_s_reg ^ ad_s_reg;
                    end
                end
                CMD_GCD_INIT:
                begin
                    x_reg <= den_reg; y_reg <= num_reg;
                    if (num_reg == '0) num_s_reg <= 1'b0;
                end
                CMD_DIV_INIT, CMD_QN_INIT, CMD_QD_INIT:
                begin
                    rem_reg <= '0;
                    cnt_reg <= CW'(W2);
                    unique case (cmd)
                        CMD_DIV_INIT:
                        begin
                            dvd_reg <= x_reg; dvs_reg <= y_reg; qsel_reg <= 2'd0;
                        end
                        CMD_QN_INIT:
                        begin
                            g_reg <= x_reg;
                            dvd_reg <= num_reg; dvs_reg <= x_reg; qsel_reg <= 2'd1;
                        end
                        default:
                        begin
                            qn_reg <= quo_reg;
                            dvd_reg <= den_reg; dvs_reg <= g_reg; qsel_reg <= 2'd2;
                        end
                    endcase
                end
                CMD_DIV_STEP:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    dvd_reg <= {dvd_reg[W2-2:0], 1'b0};
                    if (!trial[W2])
                    begin
                        rem_reg <= trial[W2-1:0];
                        quo_reg <= {quo_reg[W2-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[W2-2:0], dvd_reg[W2-1]};
                        quo_reg <= {quo_reg[W2-2:0], 1'b0};
                    end
                end
                CMD_GCD_NEXT:
                begin
                    x_reg <= y_reg; y_reg <= rem_reg;
                end
                CMD_FINISH:
                begin
                    if (stat.zden)
                    begin
                        st_reg <= ST_ZDEN; rn_reg <= '0; rd_reg <= '0;
                    end
                    else if (quo_reg > lim - 1'b1 || qn_reg > (num_s_reg ? lim : lim - 1'b1))
                    begin
                        st_reg <= ST_OVF; rn_reg <= '0; rd_reg <= '0;
                    end
                    else
                    begin
                        st_reg <= ST_OK;
                        rn_reg <= num_s_reg ? 32'(-qn_reg) : qn_reg[31:0];
                        rd_reg <= quo_reg[30:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign res_num = rn_reg;
    assign res_den = rd_reg;
    assign status = st_reg;

`ifndef SYNTHESIS
    a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_DIV_STEP |-> cnt_reg != '0)
        else $error("divider stepped past its last bit");
    a_qsel: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_DIV_STEP |-> qsel_reg != 2'd3)
        else $error("divider running with no owner");
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_FINISH && st_reg == ST_OK |=> !(res_num == 32'd0 && status == ST_OK
        && res_den == 31'd0))
        else $error("ok result with zero denominator");
`endif
endmodule

// ----- src/rau_ctrl.sv -----
// Sequencer for the rational arithmetic unit: handshakes and datapath commands.
// Depends on rau_pkg.
`timescale 1ns / 1ps
module rau_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  rau_pkg::stat_t  stat,
    output rau_pkg::cmd_t   cmd
);
    import rau_pkg::*;
    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_SUM, S_GINIT, S_GTEST, S_GDIV, S_GNEXT,
        S_QNRUN, S_QD, S_QDRUN, S_FIN, S_OUT
    } state_t;
    state_t state_reg;
    logic ovalid_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  cmd = in_valid ? CMD_LOAD : CMD_NONE;
            S_MUL1:  cmd = CMD_MUL1;
            S_MUL2:  cmd = CMD_MUL2;
            S_SUM:   cmd = CMD_SUM;
            // a zero denominator finishes right after the products
            S_GINIT: cmd = stat.zden ? CMD_FINISH : CMD_GCD_INIT;
            S_GTEST: cmd = stat.gcd_done ? CMD_QN_INIT : CMD_DIV_INIT;
            S_GDIV:  cmd = stat.div_done ? CMD_GCD_NEXT : CMD_DIV_STEP;
            S_QNRUN: cmd = stat.div_done ? CMD_QD_INIT : CMD_DIV_STEP;
            S_QDRUN: cmd = stat.div_done ? CMD_FINISH : CMD_DIV_STEP;
            default: cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:  if (in_valid) state_reg <= S_MUL1;
                S_MUL1:  state_reg <= S_MUL2;
                S_MUL2:  state_reg <= S_SUM;
                S_SUM:   state_reg <= S_GINIT;
                // zero denominators skip the GCD and the reduction
                S_GINIT: state_reg <= stat.zden ? S_QD : S_GTEST;
                S_GTEST: state_reg <= stat.gcd_done ? S_QNRUN : S_GDIV;
                S_GDIV:  if (stat.div_done) state_reg <= S_GTEST;
                S_QNRUN: if (stat.div_done) state_reg <= S_QDRUN;
                S_QD:    state_reg <= S_FIN;
                S_QDRUN:
                begin
                    if (stat.div_done)
                    begin
                        state_reg <= S_OUT; ovalid_reg <= 1'b1;
                    end
                end
                S_FIN:
                begin
                    state_reg <= S_OUT; ovalid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE; ovalid_reg <= 1'b0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // zero-denominator path issues finish from S_GINIT and then only waits
`ifndef SYNTHESIS
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT)
        else $error("result shown outside output state");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
`endif
endmodule

// ----- bench/rational_arithmetic_unit_tb.sv -----
// Self-checking bench for rational_arithmetic_unit: fraction requests in, reduced results out.
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int WIDTH = DEF_WIDTH;
    localparam int WATCHDOG = 50000;

    // first member sits in the top bits; func ends up in the low bits of tdata
    typedef struct packed {
        logic [31:0] b_den;
        logic [31:0] b_num;
        logic [31:0] a_den;
        logic [31:0] a_num;
        logic [2:0]  func;
    } frac_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [30:0] den;
        logic [31:0] num;
    } frac_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;

    frac_req_t pending_reqs[$];
    frac_res_t expected_fracs[$];
    int  mismatches;
    int  idle_cycles;
    bit  all_queued;
    bit  hold_off_now;
    bit  drain_pause;
    int  sink_gap;
    int  src_gap;
    int  req_count;

    rational_arithmetic_unit #(.WIDTH(WIDTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int rand_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 150);
        else if ($urandom_range(0, 2) == 0)
            return 0;
        else
            return $urandom_range(1, 4);
    endfunction

    // Split a WIDTH-bit operand into sign and magnitude.
    function automatic void split_op(input logic [31:0] raw, output bit neg,
                                     output logic [63:0] mag);
        logic [63:0] v;
        v = 64'(raw) & ((64'd1 << WIDTH) - 1);
        neg = v[WIDTH-1];
        mag = neg ? ((64'd1 << WIDTH) - v) : v;
    endfunction

    function automatic void sm_sum(input bit xn, input logic [63:0] xm, input bit yn,
                                   input logic [63:0] ym, output bit rn,
                                   output logic [63:0] rm);
        if (xn == yn)
        begin
            rm = xm + ym;
            rn = xn;
        end
        else if (xm >= ym)
        begin
            rm = xm - ym;
            rn = xn;
        end
        else
        begin
            rm = ym - xm;
            rn = yn;
        end
        if (rm == 0)
            rn = 1'b0;
    endfunction

    function automatic frac_res_t reduce_fraction(input frac_req_t r);
        frac_res_t   res;
        bit          an_s, ad_s, bn_s, bd_s, n_s, p_s, q_s;
        logic [63:0] an, ad, bn, bd, nm, dm, pm, qm, x, y, t, lim;
        bit          binop;
        res = '0;
        lim = 64'd1 << (WIDTH - 1);
        split_op(r.a_num, an_s, an);
        split_op(r.a_den, ad_s, ad);
        split_op(r.b_num, bn_s, bn);
        split_op(r.b_den, bd_s, bd);
        binop = (r.func >= FN_ADD && r.func <= FN_DIV);
        if (ad == 0 || (binop && bd == 0) || (r.func == FN_DIV && bn == 0))
        begin
            res.status = ST_ZDEN;
            return res;
        end
        // only the signs' parity matters once the sign moves to the numerator
        case (r.func)
            FN_ADD, FN_SUB:
            begin
                if (r.func == FN_SUB)
                    bn_s = (bn != 0) && !bn_s;
                pm = an * bd;
                p_s = (pm != 0) && (an_s != bd_s);
                qm = bn * ad;
                q_s = (qm != 0) && (bn_s != ad_s);
                sm_sum(p_s, pm, q_s, qm, n_s, nm);
                dm = ad * bd;
                n_s = (nm != 0) && (n_s != (ad_s != bd_s));
            end
            FN_MUL:
            begin
                nm = an * bn;
                dm = ad * bd;
                n_s = (nm != 0) && ((an_s ^ bn_s) != (ad_s ^ bd_s));
            end
            FN_DIV:
            begin
                nm = an * bd;
                dm = ad * bn;
                n_s = (nm != 0) && ((an_s ^ bd_s) != (ad_s ^ bn_s));
            end
            default:
            begin
                nm = an;
                dm = ad;
                n_s = (nm != 0) && (an_s != ad_s);
            end
        endcase
        x = dm;
        y = nm;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        nm = nm / x;
        dm = dm / x;
        if (dm > lim - 1 || nm > (n_s ? lim : lim - 1))
        begin
            res.status = ST_OVF;
            return res;
        end
        res.num = n_s ? 32'(-nm) : nm[31:0];
        res.den = dm[30:0];
        res.status = ST_OK;
        return res;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 40)) - 20);
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            3: return 32'($urandom_range(1, 1000)) * 32'($urandom_range(1, 1000));
            4: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 32'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_req(input logic [2:0] f, input logic [31:0] an, input logic [31:0] ad,
                            input logic [31:0] bn, input logic [31:0] bd);
        frac_req_t r;
        r.func = f;
        r.a_num = an;
        r.a_den = ad;
        r.b_num = bn;
        r.b_den = bd;
        pending_reqs.push_back(r);
    endtask

    initial
    begin
        logic [2:0] f;
        rst_n = 1'b0;
        all_queued = 1'b0;
        mismatches = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        push_req(FN_NORM, 32'd6, 32'd4, 0, 0);
        push_req(FN_NORM, 32'd3, -32'sd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(FN_NORM, 32'h8000_0000, 32'd1, 0, 0);
        push_req(FN_NORM, 32'h8000_0000, -32'sd1, 0, 0);
        push_req(FN_NORM, 32'd5, 32'h8000_0000, 0, 0);
        push_req(FN_NORM, 0, -32'sd7, 0, 0);
        push_req(FN_NORM, 32'd1, 0, 0, 0);
        push_req(FN_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        push_req(FN_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
        push_req(FN_ADD, 32'd1, 32'd2, 32'd1, 0);
        push_req(FN_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
        push_req(FN_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
        push_req(FN_SUB, -32'sd3, 32'd4, 32'd5, -32'sd6);
        push_req(FN_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_req(FN_MUL, 32'h7FFF_FFFF, 32'd1, 32'd2, 32'd1);
        push_req(FN_MUL, -32'sd2, 32'd3, 32'd3, -32'sd2);
        push_req(FN_DIV, 32'd1, 32'd2, 0, 32'd5);
        push_req(FN_DIV, 32'd3, 32'd4, -32'sd3, 32'd8);
        push_req(FN_DIV, 32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
        push_req(3'd5, 32'd10, 32'd4, 32'd9, 32'd9);
        push_req(3'd6, -32'sd10, 32'd4, 0, 0);
        push_req(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
        for (int i = 0; i < 1830; i++)
        begin
            f = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(FN_NORM, FN_DIV));
            push_req(f, rand_operand(),
                     $urandom_range(0, 30) == 0 ? 32'd0 : rand_operand(),
                     $urandom_range(0, 30) == 0 ? 32'd0 : rand_operand(),
                     $urandom_range(0, 30) == 0 ? 32'd0 : rand_operand());
        end
        all_queued = 1'b1;
    end

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            src_gap       <= 0;
            req_count     <= 0;
            drain_pause   <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_fracs.push_back(reduce_fraction(frac_req_t'(s_axis_tdata[130:0])));
                req_count <= req_count + 1;
                if (req_count == 900)
                    drain_pause <= 1'b1;
            end
            if (drain_pause && expected_fracs.size() == 0 && !m_axis_tvalid)
                drain_pause <= 1'b0;
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (src_gap > 0 || drain_pause || pending_reqs.size() == 0
                    || (s_axis_tvalid && s_axis_tready && req_count == 900))
                begin
                    s_axis_tvalid <= 1'b0;
                    if (src_gap > 0)
                        src_gap <= src_gap - 1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {5'd0, pending_reqs.pop_front()};
                    src_gap <= (req_count > 1200 && req_count < 1400) ? 0 : rand_gap();
                end
            end
        end
    end

    // Result monitor and sink.
    always @(posedge clk or negedge rst_n)
    begin
        frac_res_t got, want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap      <= 0;
            hold_off_now  <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = frac_res_t'(m_axis_tdata[64:0]);
                if (expected_fracs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    want = expected_fracs.pop_front();
                    if (got.num !== want.num || got.den !== want.den
                        || got.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: num %h/%h den %h/%h status %0d/%0d (exp/got)",
                                     want.num, got.num, want.den, got.den,
                                     want.status, got.status);
                    end
                end
            end
            // hold off for a long stretch once, so the input stalls
            if (req_count == 400 && !hold_off_now && sink_gap == 0)
            begin
                hold_off_now  <= 1'b1;
                sink_gap      <= 3000;
                m_axis_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap      <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else if (req_count > 1200 && req_count < 1400)
            begin
                m_axis_tready <= 1'b1;
            end
            else if (m_axis_tready && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                sink_gap      <= rand_gap();
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog and end of run.
    initial
    begin
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (!(all_queued && pending_reqs.size() == 0 && !s_axis_tvalid
                 && expected_fracs.size() == 0))
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
        repeat (700) @(posedge clk);
        if (mismatches == 0 && expected_fracs.size() == 0 && !m_axis_tvalid)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
